@@ hdl/pfb_pkg.sv @@
// Shared types and constants for the page framebuffer disc fill engine.
`default_nettype none
package pfb_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// Rows held by one page byte, and the shift that maps a row to its page.
	localparam int ROWS_PER_PAGE = 8;
	localparam int PAGE_SHIFT    = 3;
	localparam int ROW_MASK      = 7;

	// Coordinate difference (column or row minus a 9-bit signed center).
	localparam int CW  = 10;
	// Square of a coordinate difference.
	localparam int SQW = 2 * CW;
	// Per-row threshold: radius squared minus row distance squared, signed.
	localparam int THW = SQW + 1;
	// Radius squared.
	localparam int R2W = 14;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_PIXEL = 2'd1,
		MODE_DISC  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_RD_WAIT,
		ST_THR,
		ST_SCAN,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

@@ hdl/pfb_store.sv @@
// Frame store: single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pfb_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hdl/page_framebuffer_circle_fill_unit.sv @@
// Top level: page-mode monochrome framebuffer with pixel, disc fill, clear and read commands.
//
// Usage: drive mode, pos_x, pos_y, radius and pixel_on and raise start; the command is
// taken at a rising edge where start is high and busy is low. Each command yields one
// result word: done is high for exactly one cycle with read_data and status valid.
// The receiver cannot stall; done is never held.
// Steps from accept to done:
//   read byte: read issued at accept, data taken in ST_RD_WAIT; off-screen: done registered at accept
//   write pixel: read, modify, write back through the one RAM read port
//   clear: every store byte is zeroed, one byte written per cycle
//   disc fill: per page, the row thresholds are built row by row with one squarer,
//   then one byte per cycle streams through a read / square / mask-and-write pipeline,
//   then the pipeline drains
// The next command is taken in the cycle that done is shown.
// Reset: a clearing pass zeroes the store, with busy high and no
// done pulse. Throughput is one command at a time; the RAM port sets the rate.
`default_nettype none
module page_framebuffer_circle_fill_unit #(
	parameter int SCREEN_WIDTH  = pfb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = pfb_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        mode,
	input  wire logic signed [8:0] pos_x,
	input  wire logic signed [8:0] pos_y,
	input  wire logic [6:0]        radius,
	input  wire logic              pixel_on,
	output logic                   done,
	output logic [7:0]             read_data,
	output logic                   status
);

	localparam int PAGE_COUNT  = (SCREEN_HEIGHT + pfb_pkg::ROWS_PER_PAGE - 1)
		/ pfb_pkg::ROWS_PER_PAGE;
	localparam int STORE_BYTES = PAGE_COUNT * SCREEN_WIDTH;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int XW          = $clog2(SCREEN_WIDTH);
	localparam int YW          = PW + pfb_pkg::PAGE_SHIFT;

	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] pg,
		input logic [XW-1:0] col);
		return AW'(int'(pg) * SCREEN_WIDTH + int'(col));
	endfunction

	pfb_pkg::state_t state_q, state_d;

	// Command registers
	logic signed [8:0]        cx_q, cy_q;
	logic [pfb_pkg::R2W-1:0]  r2_q;
	logic [AW-1:0]            addr_q;
	logic [7:0]               bit_q;
	logic                     lit_q;
	logic                     emit_q;

	// Walk counters
	logic [AW-1:0]            clr_q;
	logic [PW-1:0]            page_q;
	logic [2:0]               row_q;
	logic [XW-1:0]            col_q;

	logic signed [pfb_pkg::THW-1:0] thr_q [pfb_pkg::ROWS_PER_PAGE];

	// Scan pipeline
	logic                           v_s1, v_s2;
	logic [AW-1:0]                  addr_s1, addr_s2;
	logic signed [pfb_pkg::CW-1:0]  dx_s1;
	logic signed [pfb_pkg::SQW-1:0] dx2_s2;
	logic [7:0]                     data_s2;

	logic                done_q, status_q;
	logic [7:0]          read_data_q;

	// RAM port
	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [7:0]          mem_wdata, mem_rdata;

	logic                accept, on_screen, last_page, last_col, last_clr, scan_issue;
	logic [AW-1:0]       cmd_addr;
	logic [YW-1:0]       y_row;
	logic                row_in;
	logic signed [pfb_pkg::CW-1:0]  dy, dx;
	logic signed [pfb_pkg::SQW-1:0] dy_sq;
	logic signed [pfb_pkg::THW-1:0] thr_new;
	logic [7:0]          disc_mask;

	pfb_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign on_screen = !pos_x[8] && ({1'b0, pos_x[7:0]} < 9'(SCREEN_WIDTH))
		&& !pos_y[8] && ({1'b0, pos_y[7:0]} < 9'(SCREEN_HEIGHT));
	assign cmd_addr  = addr_of(pos_y[YW-1:pfb_pkg::PAGE_SHIFT], pos_x[XW-1:0]);
	assign last_page = (page_q == PW'(PAGE_COUNT - 1));
	assign last_col  = (col_q == XW'(SCREEN_WIDTH - 1));
	assign last_clr  = (clr_q == AW'(STORE_BYTES - 1));

	// Row threshold for the row being set up in this page
	assign y_row   = {page_q, row_q};
	assign row_in  = ({1'b0, y_row} < (YW + 1)'(SCREEN_HEIGHT));
	assign dy      = $signed(pfb_pkg::CW'(y_row)) - pfb_pkg::CW'(cy_q);
	assign dy_sq   = pfb_pkg::SQW'(dy) * pfb_pkg::SQW'(dy);
	assign thr_new = pfb_pkg::THW'(r2_q) - pfb_pkg::THW'(dy_sq);

	assign dx = $signed(pfb_pkg::CW'(col_q)) - pfb_pkg::CW'(cx_q);

	always_comb begin
		for (int k = 0; k < pfb_pkg::ROWS_PER_PAGE; k++) begin
			disc_mask[k] = (pfb_pkg::THW'(dx2_s2) <= thr_q[k]);
		end
	end

	// Next state and RAM port control
	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		scan_issue = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = 8'd0;
		mem_raddr  = addr_q;
		unique case (state_q)
			pfb_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (last_clr) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			pfb_pkg::ST_IDLE: begin
				accept = start;
				if (start) begin
					unique case (pfb_pkg::mode_t'(mode))
						pfb_pkg::MODE_CLEAR: state_d = pfb_pkg::ST_CLEAR;
						pfb_pkg::MODE_PIXEL: state_d = on_screen ? pfb_pkg::ST_PIX_RD
							: pfb_pkg::ST_IDLE;
						pfb_pkg::MODE_DISC:  state_d = pfb_pkg::ST_THR;
						pfb_pkg::MODE_READ:  state_d = on_screen ? pfb_pkg::ST_RD_WAIT
							: pfb_pkg::ST_IDLE;
						default:             state_d = pfb_pkg::ST_IDLE;
					endcase
				end
				// issue the byte read right away for a read command
				mem_raddr = cmd_addr;
			end
			pfb_pkg::ST_PIX_RD: begin
				state_d = pfb_pkg::ST_PIX_WR;
			end
			pfb_pkg::ST_PIX_WR: begin
				mem_we    = 1'b1;
				mem_wdata = lit_q ? (mem_rdata | bit_q) : (mem_rdata & ~bit_q);
				state_d   = pfb_pkg::ST_IDLE;
			end
			pfb_pkg::ST_RD_WAIT: begin
				state_d = pfb_pkg::ST_IDLE;
			end
			pfb_pkg::ST_THR: begin
				if (row_q == 3'(pfb_pkg::ROW_MASK)) begin
					state_d = pfb_pkg::ST_SCAN;
				end
			end
			pfb_pkg::ST_SCAN: begin
				scan_issue = 1'b1;
				mem_raddr  = addr_of(page_q, col_q);
				if (last_col) begin
					state_d = pfb_pkg::ST_DRAIN;
				end
			end
			pfb_pkg::ST_DRAIN: begin
				// hold the thresholds until the last byte of the page is written back
				if (!v_s1 && !v_s2) begin
					state_d = last_page ? pfb_pkg::ST_IDLE : pfb_pkg::ST_THR;
				end
			end
			default: state_d = pfb_pkg::ST_IDLE;
		endcase
		if (v_s2) begin
			mem_we    = 1'b1;
			mem_waddr = addr_s2;
			mem_wdata = data_s2 | disc_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			page_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
			emit_q <= 1'b0;
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= scan_issue;
			v_s2   <= v_s1;
			if (accept) begin
				clr_q  <= '0;
				page_q <= '0;
				row_q  <= '0;
				col_q  <= '0;
				emit_q <= 1'b1;
				if ((pfb_pkg::mode_t'(mode) == pfb_pkg::MODE_PIXEL
					|| pfb_pkg::mode_t'(mode) == pfb_pkg::MODE_READ) && !on_screen) begin
					done_q <= 1'b1;
				end
			end
			if (state_q == pfb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
				if (last_clr) begin
					done_q <= emit_q;
				end
			end
			if (state_q == pfb_pkg::ST_PIX_WR || state_q == pfb_pkg::ST_RD_WAIT) begin
				done_q <= 1'b1;
			end
			if (state_q == pfb_pkg::ST_THR) begin
				row_q <= row_q + 3'd1;
			end
			if (state_q == pfb_pkg::ST_SCAN) begin
				col_q <= last_col ? '0 : col_q + XW'(1);
			end
			if (state_q == pfb_pkg::ST_DRAIN && !v_s1 && !v_s2) begin
				if (last_page) begin
					done_q <= 1'b1;
				end else begin
					page_q <= page_q + PW'(1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q        <= pos_x;
			cy_q        <= pos_y;
			r2_q        <= pfb_pkg::R2W'(radius) * pfb_pkg::R2W'(radius);
			addr_q      <= cmd_addr;
			bit_q       <= 8'd1 << pos_y[2:0];
			lit_q       <= pixel_on;
			read_data_q <= 8'd0;
			status_q    <= !on_screen && (pfb_pkg::mode_t'(mode) == pfb_pkg::MODE_PIXEL
				|| pfb_pkg::mode_t'(mode) == pfb_pkg::MODE_READ);
		end
		if (state_q == pfb_pkg::ST_RD_WAIT) begin
			read_data_q <= mem_rdata;
		end
		if (state_q == pfb_pkg::ST_THR) begin
			thr_q[row_q] <= row_in ? thr_new : '1;
		end
		addr_s1 <= mem_raddr;
		dx_s1   <= dx;
		addr_s2 <= addr_s1;
		dx2_s2  <= pfb_pkg::SQW'(dx_s1) * pfb_pkg::SQW'(dx_s1);
		data_s2 <= mem_rdata;
	end

	assign busy      = (state_q != pfb_pkg::ST_IDLE);
	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	// A result word only appears once the engine is free again
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word shown while busy");

	// Scan write-backs stay inside the disc phases
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == pfb_pkg::ST_SCAN || state_q == pfb_pkg::ST_DRAIN))
		else $error("scan write-back outside disc fill");

	// A disc command always takes the engine busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == pfb_pkg::MODE_DISC) |=> busy)
		else $error("disc command did not start");

	// Thresholds are rebuilt only with the scan pipeline empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfb_pkg::ST_THR) |-> (!v_s1 && !v_s2))
		else $error("thresholds changed under an active scan");

endmodule
`default_nettype wire
